[hdl/bcv_pkg.sv]
// Package with the discharge curve, field widths and the job record shared by the block.
package bcv_pkg;

  localparam int CurvePoints = 11;
  localparam int Segments    = CurvePoints - 1;

  localparam int VoltW = 16;
  localparam int PctW  = 7;
  localparam int DenW  = 11;
  localparam int OffW  = DenW;
  localparam int ProdW = OffW + PctW;
  localparam int NumW  = ProdW + 2;
  localparam int DivW  = DenW + 1;
  localparam int QuoW  = PctW;

  localparam logic [VoltW-1:0] CurveMv [CurvePoints] = '{
    16'd8400, 16'd8100, 16'd7838, 16'd7609, 16'd7508, 16'd7414,
    16'd7326, 16'd7243, 16'd7166, 16'd7020, 16'd6000
  };

  localparam logic [PctW-1:0] CurvePct [CurvePoints] = '{
    7'd100, 7'd94, 7'd77, 7'd62, 7'd53, 7'd41, 7'd27, 7'd15, 7'd8, 7'd3, 7'd0
  };

  localparam logic [PctW-1:0] PctFull  = 7'd100;
  localparam logic [PctW-1:0] PctEmpty = 7'd0;

  // One classified beat: base percentage, segment rise, offset into the segment, segment span.
  typedef struct packed {
    logic [PctW-1:0] p_lo;
    logic [PctW-1:0] dp;
    logic [OffW-1:0] off;
    logic [DenW-1:0] den;
  } job_t;

endpackage

[hdl/bcv_front.sv]
// Front end: finds the curve segment for a voltage and forms its interpolation job.
module bcv_front (
  input  logic [bcv_pkg::VoltW-1:0] voltage_mv_i,
  output bcv_pkg::job_t             job_o
);

  logic [bcv_pkg::VoltW-1:0] off_full;
  logic [bcv_pkg::VoltW-1:0] den_full;
  logic [bcv_pkg::PctW-1:0]  dp_full;

  always_comb begin
    off_full     = '0;
    den_full     = '0;
    dp_full      = '0;
    job_o.p_lo   = bcv_pkg::PctEmpty;
    job_o.dp     = '0;
    job_o.off    = '0;
    job_o.den    = bcv_pkg::DenW'(1);
    if (voltage_mv_i >= bcv_pkg::CurveMv[0]) begin
      job_o.p_lo = bcv_pkg::PctFull;
    end else if (voltage_mv_i > bcv_pkg::CurveMv[bcv_pkg::CurvePoints-1]) begin
      // Walk from the low end; the segments do not overlap, so at most one of them matches.
      for (int k = bcv_pkg::Segments - 1; k >= 0; k--) begin
        if (voltage_mv_i >= bcv_pkg::CurveMv[k+1] && voltage_mv_i < bcv_pkg::CurveMv[k]) begin
          off_full   = voltage_mv_i - bcv_pkg::CurveMv[k+1];
          den_full   = bcv_pkg::CurveMv[k] - bcv_pkg::CurveMv[k+1];
          dp_full    = bcv_pkg::CurvePct[k] - bcv_pkg::CurvePct[k+1];
          job_o.p_lo = bcv_pkg::CurvePct[k+1];
          job_o.dp   = dp_full;
          job_o.off  = off_full[bcv_pkg::OffW-1:0];
          job_o.den  = den_full[bcv_pkg::DenW-1:0];
        end
      end
    end
  end

endmodule

[hdl/bcv_queue.sv]
// Two-entry queue of classified jobs between the front end and the back end.
module bcv_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  bcv_pkg::job_t push_job_i,
  input  logic          pop_i,
  output logic          full_o,
  output logic          valid_o,
  output bcv_pkg::job_t head_o
);

  bcv_pkg::job_t mem_q [2];
  logic          wr_ptr_q, wr_ptr_d;
  logic          rd_ptr_q, rd_ptr_d;
  logic [1:0]    cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

[hdl/bcv_back.sv]
// Back end: multiply, then a pipelined restoring divider that rounds to nearest.
module bcv_back (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     job_valid_i,
  input  bcv_pkg::job_t            job_i,
  output logic                     job_pop_o,
  output logic                     valid_o,
  input  logic                     stall_i,
  output logic [bcv_pkg::PctW-1:0] charge_percent_o
);

  localparam int NumW = bcv_pkg::NumW;
  localparam int QuoW = bcv_pkg::QuoW;

  logic                     vld_q  [QuoW];
  logic [NumW-1:0]          rem_q  [QuoW];
  logic [QuoW-1:0]          quo_q  [QuoW];
  logic [bcv_pkg::DivW-1:0] dv_q   [QuoW];
  logic [bcv_pkg::PctW-1:0] plo_q  [QuoW];
  logic                     out_vld_q;
  logic [bcv_pkg::PctW-1:0] charge_q;

  logic                      adv;
  logic [bcv_pkg::ProdW-1:0] prod;
  logic [NumW-1:0]           num0;

  logic [NumW-1:0]          rem_d [QuoW];
  logic [QuoW-1:0]          quo_d [QuoW];
  logic [NumW-1:0]          last_div;
  logic                     last_bit;
  logic [bcv_pkg::PctW-1:0] charge_d;

  // The whole back end moves together unless a finished beat is held at the output.
  assign adv       = !out_vld_q || !stall_i;
  assign job_pop_o = adv && job_valid_i;

  // Rounded quotient of 2*off*dp + den over 2*den.
  assign prod = bcv_pkg::ProdW'(job_i.off) * bcv_pkg::ProdW'(job_i.dp);
  assign num0 = NumW'({prod, 1'b0}) + NumW'(job_i.den);

  assign rem_d[0] = num0;
  assign quo_d[0] = '0;

  for (genvar j = 1; j < QuoW; j++) begin : g_step
    logic [NumW-1:0] div_sh;
    assign div_sh = NumW'(dv_q[j-1]) << (QuoW - j);
    always_comb begin
      rem_d[j] = rem_q[j-1];
      quo_d[j] = quo_q[j-1];
      if (rem_q[j-1] >= div_sh) begin
        rem_d[j]          = rem_q[j-1] - div_sh;
        quo_d[j][QuoW-j]  = 1'b1;
      end
    end
  end

  assign last_div = NumW'(dv_q[QuoW-1]);
  assign last_bit = (rem_q[QuoW-1] >= last_div);
  assign charge_d = plo_q[QuoW-1] + (quo_q[QuoW-1] | QuoW'(last_bit));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < QuoW; i++) begin
        vld_q[i] <= 1'b0;
      end
      out_vld_q <= 1'b0;
    end else if (adv) begin
      vld_q[0] <= job_valid_i;
      for (int i = 1; i < QuoW; i++) begin
        vld_q[i] <= vld_q[i-1];
      end
      out_vld_q <= vld_q[QuoW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rem_q[0] <= rem_d[0];
      quo_q[0] <= quo_d[0];
      dv_q[0]  <= {job_i.den, 1'b0};
      plo_q[0] <= job_i.p_lo;
      for (int i = 1; i < QuoW; i++) begin
        rem_q[i] <= rem_d[i];
        quo_q[i] <= quo_d[i];
        dv_q[i]  <= dv_q[i-1];
        plo_q[i] <= plo_q[i-1];
      end
      charge_q <= charge_d;
    end
  end

  assign valid_o          = out_vld_q;
  assign charge_percent_o = charge_q;

endmodule

[hdl/battery_charge_from_voltage.sv]
// Throughput: one beat per cycle while stall_i is low; the back end is a multiply stage and a seven-step
// divider pipeline that all advance together, with a two-entry queue in front of it.
// Reset: rst_ni clears the queue pointers and count and all valid flags asynchronously; data registers are not reset.
// Charge is interpolated on the fixed discharge curve and rounded to nearest, halves up.
module battery_charge_from_voltage (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  output logic                     stall_o,
  input  logic [bcv_pkg::VoltW-1:0] voltage_mv_i,
  output logic                     valid_o,
  input  logic                     stall_i,
  output logic [bcv_pkg::PctW-1:0] charge_percent_o
);

  bcv_pkg::job_t front_job;
  bcv_pkg::job_t head_job;
  logic          q_full;
  logic          q_vld;
  logic          q_pop;
  logic          in_accept;

  assign stall_o   = q_full;
  assign in_accept = valid_i && !q_full;

  bcv_front u_front (
    .voltage_mv_i (voltage_mv_i),
    .job_o        (front_job)
  );

  bcv_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (in_accept),
    .push_job_i (front_job),
    .pop_i      (q_pop),
    .full_o     (q_full),
    .valid_o    (q_vld),
    .head_o     (head_job)
  );

  bcv_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .job_valid_i      (q_vld),
    .job_i            (head_job),
    .job_pop_o        (q_pop),
    .valid_o          (valid_o),
    .stall_i          (stall_i),
    .charge_percent_o (charge_percent_o)
  );

  a_charge_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (charge_percent_o <= bcv_pkg::PctFull))
    else $error("charge above full scale");

  a_full_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_full |-> q_vld)
    else $error("queue full but reports no head entry");

  a_pop_needs_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_vld)
    else $error("back end popped an empty queue");

  a_stall_holds_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && stall_i) |=> (valid_o && $stable(charge_percent_o)))
    else $error("held result beat changed under stall");

endmodule
